/* design/smx_pkg.sv */
// smx_pkg: types, constants and exponential tables for the softmax confidence block
// no dependencies
`timescale 1ns / 1ps
package smx_pkg;
	localparam int IdxW = 14;
	localparam int LogitW = 16;
	localparam int SumW = 32;
	localparam int ConfW = 16;
	localparam int MaxTokensDefault = 16384;
	localparam logic [IdxW-1:0] BlankReset = 14'd9997;
	localparam logic [SumW-1:0] OneQ18 = 32'd262144;
	localparam logic [16:0] Log2eQ16 = 17'd94548;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXP,
		ST_MUL,
		ST_UPD,
		ST_DIV,
		ST_OUT
	} state_t;

	// 2^(-i/16) in Q0.18
	function automatic logic [18:0] coarse_pow(input logic [3:0] i);
		logic [18:0] v;
		case (i)
			4'd0: v = 19'd262144;
			4'd1: v = 19'd251030;
			4'd2: v = 19'd240387;
			4'd3: v = 19'd230195;
			4'd4: v = 19'd220436;
			4'd5: v = 19'd211090;
			4'd6: v = 19'd202141;
			4'd7: v = 19'd193571;
			4'd8: v = 19'd185364;
			4'd9: v = 19'd177505;
			4'd10: v = 19'd169979;
			4'd11: v = 19'd162773;
			4'd12: v = 19'd155872;
			4'd13: v = 19'd149263;
			4'd14: v = 19'd142935;
			default: v = 19'd136875;
		endcase
		return v;
	endfunction

	// 2^(-i/256) in Q0.18
	function automatic logic [18:0] fine_pow(input logic [3:0] i);
		logic [18:0] v;
		case (i)
			4'd0: v = 19'd262144;
			4'd1: v = 19'd261435;
			4'd2: v = 19'd260728;
			4'd3: v = 19'd260023;
			4'd4: v = 19'd259320;
			4'd5: v = 19'd258619;
			4'd6: v = 19'd257920;
			4'd7: v = 19'd257222;
			4'd8: v = 19'd256527;
			4'd9: v = 19'd255833;
			4'd10: v = 19'd255141;
			4'd11: v = 19'd254452;
			4'd12: v = 19'd253763;
			4'd13: v = 19'd253077;
			4'd14: v = 19'd252393;
			default: v = 19'd251711;
		endcase
		return v;
	endfunction
endpackage

/* design/softmax_top_confidence.sv */
// softmax_top_confidence: streaming softmax probability of the top token
// depends on smx_pkg
`timescale 1ns / 1ps
// channel  dir  signals                              contents
// s_axis   in   s_tvalid s_tready s_tdata s_tlast    logit per item, last marks frame end
// m_axis   out  m_tvalid m_tready m_tdata m_tuser    confidence, best_index; is_blank
// cfg      in   cfg_valid cfg_ready cfg_data         blank_index
//
// each item passes the accept, exponent, multiply and update steps through the one
// shared 34x19 multiplier; a last item then adds restoring division (35
// quotient bits, one a cycle, then the saturate and blank step) and the output
// state. the input is not ready while an item is at work or a result waits on
// m_tready. arst_n resets all state; blank_index returns to its reset value.
module softmax_top_confidence #(
	parameter int MAX_TOKENS = smx_pkg::MaxTokensDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // logit[15:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // confidence[15:0], best_index[29:16]
	output logic        m_tuser,   // is_blank[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [13:0] cfg_data   // blank_index
);
	localparam int IdxW = smx_pkg::IdxW;
	localparam logic [IdxW-1:0] Limit = IdxW'((MAX_TOKENS - 1) % (1 << IdxW));

	smx_pkg::state_t state_q, state_d;
	logic [IdxW-1:0] blank_q, pos_q, cnt_q;
	logic signed [15:0] max_q, x_q;
	logic [31:0] sum_q;
	logic last_q, gt_q;
	logic [4:0] n_q;
	logic [33:0] mula_q;
	logic [18:0] mulb_q;
	logic [5:0] dcnt_q;
	logic [34:0] rem_q;
	logic [34:0] quo_q;
	logic [15:0] conf_q;
	logic blank_hit_q;

	// shared multiplier
	logic [52:0] prod;
	assign prod = {19'd0, mula_q} * {34'd0, mulb_q};

	logic signed [16:0] diff;
	assign diff = signed'(s_tdata) > max_q ? 17'(signed'(s_tdata)) - 17'(max_q)
		: 17'(max_q) - 17'(signed'(s_tdata));

	assign s_tready = (state_q == smx_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = (state_q == smx_pkg::ST_OUT);
	assign m_tdata = {2'b00, pos_q, conf_q};
	assign m_tuser = blank_hit_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			smx_pkg::ST_IDLE: if (s_tvalid) state_d = smx_pkg::ST_EXP;
			smx_pkg::ST_EXP: state_d = smx_pkg::ST_MUL;
			smx_pkg::ST_MUL: state_d = smx_pkg::ST_UPD;
			smx_pkg::ST_UPD: state_d = last_q ? smx_pkg::ST_DIV : smx_pkg::ST_IDLE;
			smx_pkg::ST_DIV: if (dcnt_q == 6'd0) state_d = smx_pkg::ST_OUT;
			smx_pkg::ST_OUT: if (m_tready) state_d = smx_pkg::ST_IDLE;
			default: state_d = smx_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= smx_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) blank_q <= smx_pkg::BlankReset;
		else if (cfg_valid) blank_q <= cfg_data;
	end

	// datapath
	logic [18:0] e_val;
	logic [33:0] scaled;
	logic [32:0] acc;
	logic [35:0] trial;
	// exponential: round the table product to Q0.18, then shift down by n
	assign e_val = n_q == 5'd31 ? 19'd0 : 19'(((prod + 53'd131072) >> 18) >> n_q);
	// rising max uses sum*E from the multiplier plus one, otherwise sum plus E
	assign scaled = 34'((prod + 53'd131072) >> 18);
	assign acc = gt_q ? 33'(scaled) + 33'(smx_pkg::OneQ18)
		: {1'b0, sum_q} + {14'd0, mulb_q};
	assign trial = {rem_q, quo_q[34]} - {4'd0, sum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 16'sh8000;
			pos_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			x_q <= '0;
			last_q <= 1'b0;
			gt_q <= 1'b0;
			n_q <= '0;
			mula_q <= '0;
			mulb_q <= '0;
			dcnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			conf_q <= '0;
			blank_hit_q <= 1'b0;
		end else begin
			case (state_q)
				smx_pkg::ST_IDLE: if (s_tvalid) begin
					x_q <= signed'(s_tdata);
					last_q <= s_tlast;
					gt_q <= signed'(s_tdata) > max_q;
					mula_q <= 34'(diff[15:0]);
					mulb_q <= 19'(smx_pkg::Log2eQ16);
				end
				smx_pkg::ST_EXP: begin
					// u = t * log2e; split into shift and table indices
					n_q <= prod[52:24] >= 29'd19 ? 5'd31 : prod[28:24];
					mula_q <= 34'(smx_pkg::coarse_pow(prod[23:20]));
					mulb_q <= smx_pkg::fine_pow(prod[19:16]);
				end
				smx_pkg::ST_MUL: begin
					// keep E and load sum*E for the rescale of a rising max
					mula_q <= {2'b00, sum_q};
					mulb_q <= e_val;
				end
				smx_pkg::ST_UPD: begin
					if (gt_q) begin
						max_q <= x_q;
						pos_q <= cnt_q;
					end
					if (!last_q && cnt_q < Limit) cnt_q <= cnt_q + 1'b1;
					sum_q <= acc[32] ? 32'hFFFFFFFF : acc[31:0];
					dcnt_q <= 6'd35;
					rem_q <= '0;
					quo_q <= 35'h4_0000_0000;
				end
				smx_pkg::ST_DIV: begin
					if (dcnt_q != 6'd0) begin
						if (!trial[35]) begin
							rem_q <= trial[34:0];
							quo_q <= {quo_q[33:0], 1'b1};
						end else begin
							rem_q <= {rem_q[33:0], quo_q[34]};
							quo_q <= {quo_q[33:0], 1'b0};
						end
						dcnt_q <= dcnt_q - 1'b1;
					end else begin
						blank_hit_q <= pos_q == blank_q;
						conf_q <= pos_q == blank_q ? 16'd0
							: (sum_q == 32'd0 || quo_q[34:16] != 19'd0)
								? 16'hFFFF : quo_q[15:0];
					end
				end
				smx_pkg::ST_OUT: if (m_tready) begin
					max_q <= 16'sh8000;
					pos_q <= '0;
					sum_q <= '0;
					cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	// result only after a last item
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(last_q)) else $error("result without last item");
	// blank result carries zero confidence
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[15:0] == 16'd0) else $error("blank nonzero");
	// no input taken while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("ready while result pending");
`endif
endmodule

/* bench/softmax_top_confidence_test.sv */
// softmax_top_confidence_test: self-checking bench for the streaming top-token softmax block
// depends on smx_pkg and softmax_top_confidence; a built-in predictor computes each untyped result
`timescale 1ns / 1ps
module softmax_top_confidence_test;

	localparam int CycleLimit = 2000000;

	typedef struct packed {
		logic [15:0] conf;
		logic [13:0] idx;
		logic        blk;
	} score_t;

	typedef struct packed {
		logic [15:0] logit;
		logic        lst;
		logic        typed;
		score_t      want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // logit[15:0]
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // confidence[15:0], best_index[29:16]
	logic        m_tuser;   // is_blank[0]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [13:0] cfg_data;  // blank_index

	softmax_top_confidence dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// exponent tables, 2^(-i/16) and 2^(-i/256) in Q0.18
	localparam logic [18:0] CoarseTab [16] = '{
		19'd262144, 19'd251030, 19'd240387, 19'd230195,
		19'd220436, 19'd211090, 19'd202141, 19'd193571,
		19'd185364, 19'd177505, 19'd169979, 19'd162773,
		19'd155872, 19'd149263, 19'd142935, 19'd136875};
	localparam logic [18:0] FineTab [16] = '{
		19'd262144, 19'd261435, 19'd260728, 19'd260023,
		19'd259320, 19'd258619, 19'd257920, 19'd257222,
		19'd256527, 19'd255833, 19'd255141, 19'd254452,
		19'd253763, 19'd253077, 19'd252393, 19'd251711};

	// directed frames, typed results only where they are obvious
	localparam int NumRows = 24;
	localparam row_t DirRows [NumRows] = '{
		'{16'h7FFF, 1'b1, 1'b1, '{16'd65535, 14'd0, 1'b0}},  // lone max logit
		'{16'h8000, 1'b1, 1'b1, '{16'd65535, 14'd0, 1'b0}},  // lone min logit
		'{16'h0064, 1'b0, 1'b0, '0},
		'{16'h0064, 1'b1, 1'b1, '{16'd32768, 14'd0, 1'b0}},  // tie keeps first
		'{16'h8000, 1'b0, 1'b0, '0},
		'{16'h8000, 1'b1, 1'b1, '{16'd32768, 14'd0, 1'b0}},  // min first, tie
		'{16'h7FFF, 1'b0, 1'b0, '0},
		'{16'h8000, 1'b1, 1'b1, '{16'd65535, 14'd0, 1'b0}},  // exponent underflow
		'{16'h8000, 1'b0, 1'b0, '0},
		'{16'h7FFF, 1'b1, 1'b1, '{16'd65535, 14'd1, 1'b0}},  // full-range rescale
		'{16'h0000, 1'b0, 1'b0, '0},
		'{16'h0100, 1'b0, 1'b0, '0},
		'{16'hFF00, 1'b0, 1'b0, '0},
		'{16'h0100, 1'b1, 1'b0, '0},
		'{16'h0000, 1'b0, 1'b0, '0},
		'{16'h0001, 1'b0, 1'b0, '0},
		'{16'h0002, 1'b0, 1'b0, '0},
		'{16'h0003, 1'b1, 1'b0, '0},
		'{16'h0300, 1'b0, 1'b0, '0},
		'{16'h0200, 1'b0, 1'b0, '0},
		'{16'h0100, 1'b0, 1'b0, '0},
		'{16'h0000, 1'b1, 1'b0, '0},
		'{16'h1000, 1'b0, 1'b0, '0},
		'{16'h0FFF, 1'b1, 1'b0, '0}
	};

	// predictor state
	logic signed [15:0] top_logit;
	logic [13:0]        top_pos;
	logic [13:0]        next_pos;
	logic [31:0]        exp_total;
	logic [13:0]        blank_sel;

	score_t scores_due[$];
	int     errors;
	int     frames_seen;
	int     blanks_seen;
	int     items_sent;
	int     cycles;
	bit     src_idle_on;
	bit     snk_idle_on;

	// e^(-t) for t in Q8.8, result in Q0.18
	function automatic logic [18:0] exp_neg(input logic [15:0] t);
		logic [40:0] u;
		logic [7:0]  f;
		logic [37:0] m;
		u = t * 41'd94548;
		f = u[23:16];
		if (u[40:24] >= 19)
			return '0;
		m = (CoarseTab[f[7:4]] * FineTab[f[3:0]] + 38'd131072) >> 18;
		return 19'(m >> u[40:24]);
	endfunction

	function automatic logic [31:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
	endfunction

	function automatic void clear_frame();
		top_logit = 16'sh8000;
		top_pos = '0;
		exp_total = '0;
		next_pos = '0;
	endfunction

	// fold one logit into the frame, return 1 with the score on the last one
	function automatic bit fold_logit(input logic [15:0] raw, input logic lst, output score_t sc);
		logic signed [15:0] x;
		logic [15:0]        d;
		logic [63:0]        p;
		x = raw;
		sc = '0;
		if (x > top_logit) begin
			d = 16'(x - top_logit);
			p = (64'(exp_total) * exp_neg(d) + 64'd131072) >> 18;
			exp_total = sum_sat(p, 64'd262144);
			top_logit = x;
			top_pos = next_pos;
		end else begin
			d = 16'(top_logit - x);
			exp_total = sum_sat(64'(exp_total), 64'(exp_neg(d)));
		end
		if (!lst) begin
			if (next_pos != 14'h3FFF)
				next_pos++;
			return 0;
		end
		sc.idx = top_pos;
		sc.blk = (top_pos == blank_sel);
		if (exp_total == 0)
			p = 64'd65535;
		else
			p = (64'd1 << 34) / exp_total;
		sc.conf = (p > 65535) ? 16'hFFFF : p[15:0];
		if (sc.blk)
			sc.conf = '0;
		clear_frame();
		return 1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// result sink with random stalls
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (snk_idle_on && $urandom_range(0, 9) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			m_tready <= 1;
		end
	end

	// compare each result item with the oldest expected score
	always @(posedge clk) begin
		score_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (scores_due.size() == 0) begin
				report_mismatch("unexpected result, data", m_tdata, 32'd0);
			end else begin
				w = scores_due.pop_front();
				frames_seen++;
				if (m_tuser)
					blanks_seen++;
				if (m_tdata[15:0] != w.conf)
					report_mismatch("confidence", 32'(m_tdata[15:0]), 32'(w.conf));
				if (m_tdata[29:16] != w.idx)
					report_mismatch("best_index", 32'(m_tdata[29:16]), 32'(w.idx));
				if (m_tuser != w.blk)
					report_mismatch("is_blank", 32'(m_tuser), 32'(w.blk));
			end
		end
	end

	// drive one logit item and record the score it produces
	task automatic send_logit(input logic [15:0] raw, input logic lst, input bit typed,
		input score_t typed_sc);
		score_t sc;
		@(negedge clk);
		if (src_idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= raw;
		s_tlast <= lst;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		items_sent++;
		if (fold_logit(raw, lst, sc))
			scores_due.push_back(typed ? typed_sc : sc);
	endtask

	// write blank_index once the block has drained
	task automatic set_blank(input logic [13:0] v);
		@(negedge clk);
		s_tvalid <= 0;
		wait (scores_due.size() == 0);
		repeat (50) @(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		blank_sel = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// random frames: mostly short with clustered logits, some wide or long
	task automatic random_frames(input int count);
		int          stop_at;
		int          len;
		int          kind;
		logic [15:0] base;
		logic [15:0] v;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			kind = $urandom_range(0, 9);
			len = (kind == 9) ? $urandom_range(30, 200) : $urandom_range(1, 24);
			base = 16'($urandom);
			for (int i = 0; i < len; i++) begin
				case (kind)
					0, 1: v = 16'($urandom);
					2: v = base;
					3: v = base + 16'($urandom_range(0, 3));
					default: v = base + 16'($urandom_range(0, 2047)) - 16'd1024;
				endcase
				send_logit(v, i == len - 1, 0, '0);
			end
		end
	endtask

	initial begin
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		cfg_valid = 0;
		cfg_data = '0;
		errors = 0;
		frames_seen = 0;
		blanks_seen = 0;
		items_sent = 0;
		cycles = 0;
		src_idle_on = 1;
		snk_idle_on = 1;
		blank_sel = smx_pkg::BlankReset;
		clear_frame();
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed frames with the reset blank index
		for (int r = 0; r < NumRows; r++)
			send_logit(DirRows[r].logit, DirRows[r].lst, DirRows[r].typed, DirRows[r].want);

		set_blank(14'd0);
		random_frames(300);
		set_blank(14'h3FFF);
		random_frames(150);
		set_blank(14'd2);
		random_frames(150);
		set_blank(14'($urandom));
		random_frames(300);
		set_blank(14'd1);
		random_frames(300);
		set_blank(smx_pkg::BlankReset);
		random_frames(100);
		src_idle_on = 0;
		snk_idle_on = 0;
		random_frames(150);

		@(negedge clk);
		s_tvalid <= 0;
		wait (scores_due.size() == 0);
		repeat (60) @(posedge clk);
		$display("sent %0d logit items, checked %0d frame results (%0d blank)",
			items_sent, frames_seen, blanks_seen);
		$display("blank index settings 0, 1, 2, max, random and reset; extremes and ties");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
